/* hdl/rfe_pkg.sv */
// ----------------------------------------------------------------------------
// Ray feature evaluator package
// Shared defaults, fixed field widths and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

    localparam int TH_COUNT_DEF  = 4;
    localparam int ROW_COUNT_DEF = 32;
    localparam int COL_COUNT_DEF = 32;
    localparam int ANG_COUNT_DEF = 12;

    localparam int REC_W   = 64;
    localparam int DSQ_W   = 24;
    localparam int NSQ_W   = 24;
    localparam int ORI_W   = 16;
    localparam int DEG_W   = 9;
    localparam int VAL_W   = 32;

    localparam int SQ_RAD_W = 56;
    localparam int SQ_RES_W = 28;
    localparam int DV_NUM_W = 44;

    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [31:0] Q30_PI      = 32'd3373259426;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;

    localparam int HORNER_STEPS = 6;
    localparam logic [7:0]  HORNER_DIV   [HORNER_STEPS] = '{
        8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    // floor(2^34 / divisor)
    localparam logic [33:0] HORNER_RECIP [HORNER_STEPS] = '{
        34'd130150524, 34'd190887435, 34'd306783378,
        34'd572662306, 34'd1431655765, 34'd8589934592
    };

    localparam logic [1:0] KIND_DIST  = 2'd0;
    localparam logic [1:0] KIND_NORM  = 2'd1;
    localparam logic [1:0] KIND_COS   = 2'd2;
    localparam logic [1:0] KIND_DDIFF = 2'd3;

    localparam logic REQ_WRITE = 1'b0;

endpackage

`default_nettype wire

/* hdl/ray_feature_evaluator.sv */
// ----------------------------------------------------------------------------
// Ray feature evaluator
// Record store with distance, norm, cosine and distance difference evaluation.
// ----------------------------------------------------------------------------
// Usage: drive the request fields and pulse start while busy is low; the beat
// is taken at that edge and busy rises on the next cycle. A write beat stores
// one record and returns nothing. An evaluate beat returns one result, shown
// for a single cycle with o_result_valid high. An index error is reported
// without a store read. Distance or norm takes one 28-step square root,
// cosine six Horner steps (multiply, reciprocal, fix), and distance
// difference two square roots and a 44-step divider, or no root when the
// first distance is zero. The next beat may be taken in the cycle the result
// is shown. All work is serial around one store read per record. The store
// holds no defined contents after reset; read only written records.
// Reset clears the sequencer and the result strobe. The receiver cannot
// stall: each result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_feature_evaluator #(
    parameter int THRESHOLD_COUNT = rfe_pkg::TH_COUNT_DEF,
    parameter int ROW_COUNT       = rfe_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT       = rfe_pkg::COL_COUNT_DEF,
    parameter int ANGLE_COUNT     = rfe_pkg::ANG_COUNT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_req_type,
    input  wire logic [1:0]                     i_threshold_select,
    input  wire logic [4:0]                     i_row_index,
    input  wire logic [4:0]                     i_col_index,
    input  wire logic [3:0]                     i_angle_slot,
    input  wire logic [rfe_pkg::DSQ_W-1:0]      i_write_dist_sq,
    input  wire logic [rfe_pkg::NSQ_W-1:0]      i_write_norm_sq,
    input  wire logic signed [rfe_pkg::ORI_W-1:0] i_write_orient,
    input  wire logic [1:0]                     i_feature_kind,
    input  wire logic [rfe_pkg::DEG_W-1:0]      i_first_angle_deg,
    input  wire logic [rfe_pkg::DEG_W-1:0]      i_second_angle_deg,
    output logic                                o_result_valid,
    output logic signed [rfe_pkg::VAL_W-1:0]    o_feature_value,
    output logic                                o_index_error
);
    import rfe_pkg::*;

    localparam int DEPTH      = THRESHOLD_COUNT * ROW_COUNT * COL_COUNT * ANGLE_COUNT;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_STEP  = 360 / ANGLE_COUNT;
    localparam int SLOT_SHIFT = 18;
    localparam int SLOT_RECIP = (1 << SLOT_SHIFT) / SLOT_STEP;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_FIX, S_BASE, S_ADDR, S_RD1, S_RD2, S_SQRT, S_DIV,
        S_COS_FOLD, S_COS_SQ, S_COS_MUL, S_COS_REC, S_COS_FIX, S_COS_RND
    } t_state;

    t_state r_state;

    logic                r_req;
    logic [1:0]          r_thr;
    logic [4:0]          r_row;
    logic [4:0]          r_col;
    logic [3:0]          r_wslot;
    logic [REC_W-1:0]    r_wrec;
    logic [1:0]          r_kind;
    logic [DEG_W-1:0]    r_deg1;
    logic [DEG_W-1:0]    r_deg2;
    logic [DEG_W-1:0]    r_s1;
    logic [DEG_W-1:0]    r_s2;
    logic [AW-1:0]       r_base;
    logic                r_ok1;
    logic                r_ok2;
    logic [DSQ_W-1:0]    r_a;
    logic [DSQ_W-1:0]    r_b;
    logic [ORI_W-1:0]    r_orient;
    logic [SQ_RAD_W-1:0] r_rad;
    logic [29:0]         r_rem;
    logic [SQ_RES_W-1:0] r_res;
    logic [5:0]          r_cnt;
    logic                r_pass;
    logic [SQ_RES_W-1:0] r_v1;
    logic                r_neg;
    logic [DV_NUM_W-1:0] r_num;
    logic [SQ_RES_W-1:0] r_drem;
    logic [30:0]         r_y;
    logic [31:0]         r_y2;
    logic [30:0]         r_t;
    logic [31:0]         r_p;
    logic [31:0]         r_q0;
    logic [2:0]          r_kidx;
    logic                r_valid;
    logic [VAL_W-1:0]    r_value;
    logic                r_err;

    logic [REC_W-1:0]    mem_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [AW-1:0]       addr1;
    logic [AW-1:0]       addr2;

    logic [27:0]         slot_p1;
    logic [27:0]         slot_p2;
    logic [DEG_W-1:0]    slot_r1;
    logic [DEG_W-1:0]    slot_r2;
    logic                rng_ok;

    logic [31:0]         sq_rem2;
    logic [31:0]         sq_trial;
    logic                sq_ge;
    logic [SQ_RES_W-1:0] sq_res_nx;
    logic [29:0]         sq_rem_nx;

    logic [28:0]         dv_rem2;
    logic                dv_ge;
    logic [DV_NUM_W-1:0] dv_num_nx;
    logic [SQ_RES_W-1:0] dv_rem_nx;
    logic [31:0]         dv_q;

    logic [16:0]         cs_mag;
    logic [33:0]         cs_x;
    logic [61:0]         cs_ysq;
    logic [62:0]         cs_pt;
    logic [65:0]         cs_pr;
    logic [39:0]         cs_qk;
    logic [31:0]         cs_rr;
    logic [31:0]         cs_q;
    logic [16:0]         cs_tr;

    always_comb begin
        addr1 = AW'(32'(r_base) * ANGLE_COUNT + 32'(r_s1));
        addr2 = AW'(32'(r_base) * ANGLE_COUNT + 32'(r_s2));
        mem_we = (r_state == S_ADDR) && (r_req == REQ_WRITE) && r_ok1;
        mem_raddr = (r_state == S_RD1) ? addr2 : addr1;

        slot_p1 = 28'(r_deg1 * 19'(SLOT_RECIP));
        slot_p2 = 28'(r_deg2 * 19'(SLOT_RECIP));
        slot_r1 = DEG_W'(r_deg1 - DEG_W'(32'(r_s1) * SLOT_STEP));
        slot_r2 = DEG_W'(r_deg2 - DEG_W'(32'(r_s2) * SLOT_STEP));
        rng_ok  = (32'(r_thr) < THRESHOLD_COUNT) && (32'(r_row) < ROW_COUNT) &&
                  (32'(r_col) < COL_COUNT);

        sq_rem2   = {r_rem, r_rad[SQ_RAD_W-1 -: 2]};
        sq_trial  = {2'b00, r_res, 2'b01};
        sq_ge     = sq_rem2 >= sq_trial;
        sq_res_nx = {r_res[SQ_RES_W-2:0], sq_ge};
        sq_rem_nx = sq_ge ? 30'(sq_rem2 - sq_trial) : 30'(sq_rem2);

        dv_rem2   = {r_drem, r_num[DV_NUM_W-1]};
        dv_ge     = dv_rem2 >= {1'b0, r_v1};
        dv_rem_nx = dv_ge ? SQ_RES_W'(dv_rem2 - {1'b0, r_v1}) : SQ_RES_W'(dv_rem2);
        dv_num_nx = {r_num[DV_NUM_W-2:0], dv_ge};
        dv_q      = r_neg ? 32'(32'd0 - dv_num_nx[31:0]) : dv_num_nx[31:0];

        cs_mag = r_orient[ORI_W-1] ? 17'(17'h10000 - {1'b0, r_orient}) : {1'b0, r_orient};
        cs_x   = {cs_mag, 17'b0};
        cs_ysq = r_y * r_y;
        cs_pt  = r_y2 * r_t;
        cs_pr  = r_p * HORNER_RECIP[r_kidx];
        cs_qk  = r_q0 * HORNER_DIV[r_kidx];
        cs_rr  = 32'(r_p - cs_qk[31:0]);
        cs_q   = (cs_rr >= 32'(HORNER_DIV[r_kidx])) ? 32'(r_q0 + 32'd1) : r_q0;
        cs_tr  = 17'((32'(r_t) + 32'd8192) >> 14);
    end

    rfe_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (addr1),
        .i_wdata (r_wrec),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req_type;
                        r_thr   <= i_threshold_select;
                        r_row   <= i_row_index;
                        r_col   <= i_col_index;
                        r_wslot <= i_angle_slot;
                        r_wrec  <= {i_write_orient, i_write_norm_sq, i_write_dist_sq};
                        r_kind  <= i_feature_kind;
                        r_deg1  <= i_first_angle_deg;
                        r_deg2  <= i_second_angle_deg;
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    r_s1    <= slot_p1[SLOT_SHIFT +: DEG_W];
                    r_s2    <= slot_p2[SLOT_SHIFT +: DEG_W];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_req == REQ_WRITE) begin
                        r_s1 <= DEG_W'(r_wslot);
                    end else if (32'(slot_r1) >= SLOT_STEP) begin
                        r_s1 <= DEG_W'(r_s1 + 1'b1);
                    end
                    if (32'(slot_r2) >= SLOT_STEP) begin
                        r_s2 <= DEG_W'(r_s2 + 1'b1);
                    end
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_base  <= AW'((32'(r_thr) * ROW_COUNT + 32'(r_row)) * COL_COUNT
                                   + 32'(r_col));
                    r_ok1   <= rng_ok && (32'(r_s1) < ANGLE_COUNT);
                    r_ok2   <= (r_kind != KIND_DDIFF) || (32'(r_s2) < ANGLE_COUNT);
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_req == REQ_WRITE) begin
                        r_state <= S_IDLE;
                    end else if (!r_ok1 || !r_ok2) begin
                        r_value <= '0;
                        r_err   <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_a      <= mem_rdata[DSQ_W-1:0];
                    r_orient <= mem_rdata[REC_W-1 -: ORI_W];
                    r_rem    <= '0;
                    r_res    <= '0;
                    r_cnt    <= '0;
                    r_pass   <= 1'b0;
                    case (r_kind)
                        KIND_DIST: begin
                            r_rad   <= {mem_rdata[DSQ_W-1:0], 32'b0};
                            r_state <= S_SQRT;
                        end
                        KIND_NORM: begin
                            r_rad   <= {8'b0, mem_rdata[DSQ_W +: NSQ_W], 24'b0};
                            r_state <= S_SQRT;
                        end
                        KIND_COS: begin
                            r_state <= S_COS_FOLD;
                        end
                        default: begin
                            r_state <= S_RD2;
                        end
                    endcase
                end
                S_RD2: begin
                    r_b <= mem_rdata[DSQ_W-1:0];
                    if (r_a == '0) begin
                        r_value <= (mem_rdata[DSQ_W-1:0] != '0) ? 32'h8000_0000
                                                                : 32'h7FFF_FFFF;
                        r_err   <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_rad   <= {r_a, 32'b0};
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_res <= sq_res_nx;
                    r_rem <= sq_rem_nx;
                    r_rad <= {r_rad[SQ_RAD_W-3:0], 2'b00};
                    r_cnt <= 6'(r_cnt + 1'b1);
                    if (r_cnt == 6'(SQ_RES_W - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_res <= '0;
                        if (r_kind != KIND_DDIFF) begin
                            r_value <= 32'(sq_res_nx);
                            r_err   <= 1'b0;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (!r_pass) begin
                            r_v1   <= sq_res_nx;
                            r_rad  <= {r_b, 32'b0};
                            r_pass <= 1'b1;
                        end else begin
                            r_neg   <= sq_res_nx > r_v1;
                            r_num   <= (sq_res_nx > r_v1) ?
                                       {SQ_RES_W'(sq_res_nx - r_v1), 16'b0} :
                                       {SQ_RES_W'(r_v1 - sq_res_nx), 16'b0};
                            r_drem  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_drem <= dv_rem_nx;
                    r_num  <= dv_num_nx;
                    r_cnt  <= 6'(r_cnt + 1'b1);
                    if (r_cnt == 6'(DV_NUM_W - 1)) begin
                        r_value <= dv_q;
                        r_err   <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_COS_FOLD: begin
                    if (cs_x > 34'(Q30_HALF_PI)) begin
                        r_neg <= 1'b1;
                        r_y   <= (cs_x > 34'(Q30_PI)) ? 31'(cs_x - 34'(Q30_PI))
                                                      : 31'(34'(Q30_PI) - cs_x);
                    end else begin
                        r_neg <= 1'b0;
                        r_y   <= 31'(cs_x);
                    end
                    r_state <= S_COS_SQ;
                end
                S_COS_SQ: begin
                    r_y2    <= 32'(cs_ysq >> 30);
                    r_t     <= Q30_ONE;
                    r_kidx  <= '0;
                    r_state <= S_COS_MUL;
                end
                S_COS_MUL: begin
                    r_p     <= 32'(cs_pt >> 30);
                    r_state <= S_COS_REC;
                end
                S_COS_REC: begin
                    r_q0    <= cs_pr[65:34];
                    r_state <= S_COS_FIX;
                end
                S_COS_FIX: begin
                    r_t    <= (cs_q >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - cs_q);
                    r_kidx <= 3'(r_kidx + 1'b1);
                    if (r_kidx == 3'(HORNER_STEPS - 1)) begin
                        r_state <= S_COS_RND;
                    end else begin
                        r_state <= S_COS_MUL;
                    end
                end
                S_COS_RND: begin
                    r_value <= r_neg ? 32'(32'd0 - 32'(cs_tr)) : 32'(cs_tr);
                    r_err   <= 1'b0;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_valid;
    assign o_feature_value = r_value;
    assign o_index_error   = r_err;

endmodule

`default_nettype wire

/* hdl/rfe_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/rfe_checker.sv */
// ----------------------------------------------------------------------------
// Ray feature evaluator checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_result_valid,
    input wire logic signed [rfe_pkg::VAL_W-1:0] o_feature_value,
    input wire logic                           o_index_error
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted beat");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_valid)
        else $error("result in the cycle after accept");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_index_error) |-> (o_feature_value == 0))
        else $error("index error with nonzero value");

endmodule

bind ray_feature_evaluator rfe_checker u_rfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_feature_value (o_feature_value),
    .o_index_error   (o_index_error)
);

`default_nettype wire
